@@ rtl/mme_pkg.sv @@
`timescale 1ns / 1ps

package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int ELEM_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int VALUE_W     = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PROD_W      = 2 * ELEM_WIDTH;
    localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [1:0]                opcode;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          col_index;
        logic signed [VALUE_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] product_value;
        logic [IDX_W-1:0]          out_row;
        logic [IDX_W-1:0]          out_col;
        logic                      saturated;
        logic                      last;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_dim;
        logic [DIM_W-1:0] cols_b;
    } dims_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                    kind;
        logic [ADDR_W-1:0]            addr;
        logic signed [ELEM_WIDTH-1:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN
    } back_state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

@@ rtl/mme_cmd_fifo.sv @@
`timescale 1ns / 1ps

module mme_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mme_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          cmd_valid,
    output mme_pkg::cmd_t cmd
);

    mme_pkg::cmd_t                entry_reg [mme_pkg::CMD_DEPTH];
    logic [mme_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [mme_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [mme_pkg::CMD_PTR_W:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (count_reg == (mme_pkg::CMD_PTR_W + 1)'(mme_pkg::CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/mme_front.sv @@
`timescale 1ns / 1ps

module mme_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  mme_pkg::item_t              item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]   cfg_data,
    output mme_pkg::dims_t              dims,
    output logic                        push,
    output mme_pkg::cmd_t               push_cmd,
    input  logic                        full
);

    logic [mme_pkg::DIM_W-1:0] rows_a_reg;
    logic [mme_pkg::DIM_W-1:0] inner_dim_reg;
    logic [mme_pkg::DIM_W-1:0] cols_b_reg;
    logic                      accept;
    logic                      in_range;

    assign cfg_ready  = 1'b1;
    assign item_ready = !full;
    assign accept     = item_valid && item_ready;
    assign in_range   = (int'(item.row_index) < mme_pkg::MAX_DIM)
                     && (int'(item.col_index) < mme_pkg::MAX_DIM);

    always_comb
    begin
        push_cmd.addr  = mme_pkg::ADDR_W'(item.row_index * mme_pkg::MAX_DIM
                                          + item.col_index);
        push_cmd.value = item.element_value[mme_pkg::ELEM_WIDTH-1:0];
        push_cmd.kind  = mme_pkg::CMD_COMPUTE;
        push           = 1'b0;
        unique case (item.opcode)
            mme_pkg::OP_LOAD_A:
            begin
                push_cmd.kind = mme_pkg::CMD_LOAD_A;
                push          = accept && in_range;
            end
            mme_pkg::OP_LOAD_B:
            begin
                push_cmd.kind = mme_pkg::CMD_LOAD_B;
                push          = accept && in_range;
            end
            mme_pkg::OP_COMPUTE:
            begin
                push_cmd.kind = mme_pkg::CMD_COMPUTE;
                push          = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mme_pkg::DIM_RESET;
            inner_dim_reg <= mme_pkg::DIM_RESET;
            cols_b_reg    <= mme_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mme_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                mme_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                mme_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                rows_a_reg    <= rows_a_reg;
            endcase
        end
    end

    assign dims.rows_a    = mme_pkg::clamp_dim(rows_a_reg);
    assign dims.inner_dim = mme_pkg::clamp_dim(inner_dim_reg);
    assign dims.cols_b    = mme_pkg::clamp_dim(cols_b_reg);

endmodule

@@ rtl/mme_back.sv @@
`timescale 1ns / 1ps

module mme_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mme_pkg::dims_t   dims,
    input  logic             cmd_valid,
    input  mme_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             result_valid,
    input  logic             result_ready,
    output mme_pkg::result_t result
);

    localparam int EW = mme_pkg::ELEM_WIDTH;
    localparam int AW = mme_pkg::ACC_W;
    localparam logic signed [AW-1:0] ELEM_MAX = {{(AW-EW+1){1'b0}}, {(EW-1){1'b1}}};
    localparam logic signed [AW-1:0] ELEM_MIN = {{(AW-EW+1){1'b1}}, {(EW-1){1'b0}}};

    logic signed [EW-1:0] mem_a [mme_pkg::STORE_DEPTH];
    logic signed [EW-1:0] mem_b [mme_pkg::STORE_DEPTH];

    mme_pkg::back_state_t state_reg;
    mme_pkg::back_state_t state_next;

    logic [mme_pkg::IDX_W-1:0]  i_reg;
    logic [mme_pkg::IDX_W-1:0]  j_reg;
    logic [mme_pkg::IDX_W-1:0]  p_reg;
    logic [mme_pkg::DIM_W-1:0]  m_reg;
    logic [mme_pkg::DIM_W-1:0]  n_reg;
    logic [mme_pkg::DIM_W-1:0]  k_reg;
    logic [mme_pkg::ADDR_W-1:0] a_raddr;
    logic [mme_pkg::ADDR_W-1:0] b_raddr;

    logic signed [EW-1:0]                  a_rdata_reg;
    logic signed [EW-1:0]                  b_rdata_reg;
    logic signed [mme_pkg::PROD_W-1:0]     prod_reg;
    logic signed [AW-1:0]                  acc_reg;
    logic signed [AW-1:0]                  shifted;
    logic                                  rd_vld_reg;
    logic                                  prod_vld_reg;
    logic                                  result_valid_reg;
    mme_pkg::result_t                      result_reg;

    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic emit;
    logic pipe_empty;
    logic out_free;
    logic p_last;
    logic i_last;
    logic j_last;
    logic elem_last;
    logic sat_hi;
    logic sat_lo;
    logic [EW-1:0] elem_res;

    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign out_free   = !result_valid_reg || result_ready;
    assign p_last     = (mme_pkg::DIM_W'(p_reg) + mme_pkg::DIM_W'(1)) == n_reg;
    assign i_last     = (mme_pkg::DIM_W'(i_reg) + mme_pkg::DIM_W'(1)) == m_reg;
    assign j_last     = (mme_pkg::DIM_W'(j_reg) + mme_pkg::DIM_W'(1)) == k_reg;
    assign elem_last  = i_last && j_last;

    assign a_raddr = mme_pkg::ADDR_W'(i_reg * mme_pkg::MAX_DIM + p_reg);
    assign b_raddr = mme_pkg::ADDR_W'(p_reg * mme_pkg::MAX_DIM + j_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mme_pkg::BK_IDLE:
            begin
                if (start)
                begin
                    state_next = mme_pkg::BK_MAC;
                end
            end
            mme_pkg::BK_MAC:
            begin
                if (p_last)
                begin
                    state_next = mme_pkg::BK_DRAIN;
                end
            end
            mme_pkg::BK_DRAIN:
            begin
                if (emit)
                begin
                    state_next = elem_last ? mme_pkg::BK_IDLE : mme_pkg::BK_MAC;
                end
            end
            default:
            begin
                state_next = mme_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop = 1'b0;
        wr_a    = 1'b0;
        wr_b    = 1'b0;
        start   = 1'b0;
        issue   = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            mme_pkg::BK_IDLE:
            begin
                cmd_pop = cmd_valid;
                wr_a    = cmd_valid && (cmd.kind == mme_pkg::CMD_LOAD_A);
                wr_b    = cmd_valid && (cmd.kind == mme_pkg::CMD_LOAD_B);
                start   = cmd_valid && (cmd.kind == mme_pkg::CMD_COMPUTE);
            end
            mme_pkg::BK_MAC:
            begin
                issue = 1'b1;
            end
            mme_pkg::BK_DRAIN:
            begin
                emit = pipe_empty && out_free;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[cmd.addr] <= cmd.value;
        end
        if (wr_b)
        begin
            mem_b[cmd.addr] <= cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rdata_reg <= mem_a[a_raddr];
        b_rdata_reg <= mem_b[b_raddr];
        prod_reg    <= a_rdata_reg * b_rdata_reg;
    end

    always_ff @(posedge clk)
    begin
        if (start || emit)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    assign shifted  = acc_reg >>> mme_pkg::FRAC_BITS;
    assign sat_hi   = shifted > ELEM_MAX;
    assign sat_lo   = shifted < ELEM_MIN;
    assign elem_res = sat_hi ? ELEM_MAX[EW-1:0]
                    : (sat_lo ? ELEM_MIN[EW-1:0] : shifted[EW-1:0]);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg.product_value <= mme_pkg::VALUE_W'(signed'(elem_res));
            result_reg.out_row       <= i_reg;
            result_reg.out_col       <= j_reg;
            result_reg.saturated     <= sat_hi || sat_lo;
            result_reg.last          <= elem_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mme_pkg::BK_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            p_reg            <= '0;
            m_reg            <= mme_pkg::DIM_RESET;
            n_reg            <= mme_pkg::DIM_RESET;
            k_reg            <= mme_pkg::DIM_RESET;
            rd_vld_reg       <= 1'b0;
            prod_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (start)
            begin
                i_reg <= '0;
                j_reg <= '0;
                p_reg <= '0;
                m_reg <= dims.rows_a;
                n_reg <= dims.inner_dim;
                k_reg <= dims.cols_b;
            end
            if (issue)
            begin
                p_reg <= p_last ? '0 : p_reg + 1'b1;
            end
            if (emit)
            begin
                if (j_last)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::BK_IDLE) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("multiply pipeline busy while idle");

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!result_valid_reg || result_ready))
        else $error("waiting result overwritten");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (emit || start) |=> (acc_reg == '0))
        else $error("accumulator not cleared between elements");

    a_index_in_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mme_pkg::BK_IDLE) |->
            ((mme_pkg::DIM_W'(i_reg) < m_reg) && (mme_pkg::DIM_W'(j_reg) < k_reg)
             && (mme_pkg::DIM_W'(p_reg) < n_reg)))
        else $error("element index outside dimensions");
`endif

endmodule

@@ rtl/matrix_multiply_engine.sv @@
`timescale 1ns / 1ps

// Dense Q16.16 matrix multiply, C = A x B, dimensions up to 8 each.
// Channels: item (load A element, load B element, compute), result (one
// transaction per element of C, row-major, last set on the final one) and
// cfg (rows_a, inner_dim, cols_b; write only while the block is idle).
// Every channel uses valid/ready; cfg_ready is always high.
// A load transaction is written to the store while the back end is idle; items pass through a
// four-entry command queue, so up to four loads are taken while a compute
// is still running or its results are stalled.
// A compute transaction runs in the back end as one multiply-accumulate per
// cycle over the inner dimension for each element of C, passing through the
// store read register, the product register and the accumulator.
// A stalled result holds in the output register and the back end waits;
// the front keeps taking items until the queue fills.
// Reset empties the queue, drops any pending result and sets every
// dimension to 8; store contents are undefined until loaded.
module matrix_multiply_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  mme_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output mme_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [mme_pkg::DIM_W-1:0] cfg_data
);

    mme_pkg::dims_t dims;
    mme_pkg::cmd_t  push_cmd;
    mme_pkg::cmd_t  head_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;

    mme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .dims       (dims),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full)
    );

    mme_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .cmd_valid (head_valid),
        .cmd       (head_cmd)
    );

    mme_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims),
        .cmd_valid    (head_valid),
        .cmd          (head_cmd),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ tb/matrix_multiply_engine_tb.sv @@
`timescale 1ns / 1ps

module matrix_multiply_engine_tb;

    import mme_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int unsigned RANDOM_ITEMS  = 50;
    localparam int unsigned LONG_STALL    = 400;
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned DRAIN_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT   = 2000000;

    localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [1:0]       cfg_index    = CFG_ROWS_A;
    logic [DIM_W-1:0] cfg_data     = '0;

    logic [DIM_W-1:0]          dim_rows  = DIM_RESET;
    logic [DIM_W-1:0]          dim_inner = DIM_RESET;
    logic [DIM_W-1:0]          dim_cols  = DIM_RESET;
    logic signed [VALUE_W-1:0] a_elems [STORE_DEPTH];
    logic signed [VALUE_W-1:0] b_elems [STORE_DEPTH];
    bit                        a_loaded [STORE_DEPTH];
    bit                        b_loaded [STORE_DEPTH];

    result_t     product_queue [$];
    result_t     next_elem;
    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned cycle_count    = 0;
    int unsigned rx_gap;
    bit          no_idle        = 1'b0;
    bit          long_stall_req = 1'b0;

    matrix_multiply_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
        begin
            return 1;
        end
        if (d > DIM_W'(MAX_DIM))
        begin
            return MAX_DIM;
        end
        return 32'(d);
    endfunction

    function automatic void apply_item(input item_t it);
        int unsigned        m;
        int unsigned        n;
        int unsigned        k;
        logic [ADDR_W-1:0]  addr;
        logic [ADDR_W-1:0]  a_addr;
        logic [ADDR_W-1:0]  b_addr;
        logic signed [71:0] acc;
        logic signed [71:0] ae;
        logic signed [71:0] be;
        logic signed [71:0] q;
        result_t            r;
        addr = {it.row_index, it.col_index};
        case (it.opcode)
            OP_LOAD_A:
            begin
                a_elems[addr]  = it.element_value;
                a_loaded[addr] = 1'b1;
            end
            OP_LOAD_B:
            begin
                b_elems[addr]  = it.element_value;
                b_loaded[addr] = 1'b1;
            end
            OP_COMPUTE:
            begin
                m = effective_dim(dim_rows);
                n = effective_dim(dim_inner);
                k = effective_dim(dim_cols);
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < k; j++)
                    begin
                        acc = '0;
                        for (int p = 0; p < n; p++)
                        begin
                            a_addr = ADDR_W'(i * MAX_DIM + p);
                            b_addr = ADDR_W'(p * MAX_DIM + j);
                            ae     = 72'(a_elems[a_addr]);
                            be     = 72'(b_elems[b_addr]);
                            acc    = acc + ae * be;
                        end
                        q = acc >>> FRAC_BITS;
                        r.saturated = 1'b0;
                        if (q > Q_MAX)
                        begin
                            q = Q_MAX;
                            r.saturated = 1'b1;
                        end
                        else if (q < Q_MIN)
                        begin
                            q = Q_MIN;
                            r.saturated = 1'b1;
                        end
                        r.product_value = q[VALUE_W-1:0];
                        r.out_row       = IDX_W'(i);
                        r.out_col       = IDX_W'(j);
                        r.last          = (i == m - 1) && (j == k - 1);
                        product_queue.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0:
            begin
            end
            1:
            begin
                v = VALUE_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0001_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                v = {{9{v[31]}}, v[22:0]};
            end
        endcase
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 3) != 0)
        begin
            return DIM_W'($urandom_range(1, 3));
        end
        return DIM_W'($urandom_range(0, 15));
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] val);
        item_t       it;
        int unsigned gap;
        it.opcode        = op;
        it.row_index     = row;
        it.col_index     = col;
        it.element_value = val;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        apply_item(it);
        if (op != OP_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // change dimensions only once the block has drained
    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols);
        logic [1:0]       reg_list  [3] = '{CFG_ROWS_A, CFG_INNER_DIM, CFG_COLS_B};
        logic [DIM_W-1:0] data_list [3];
        data_list[0] = rows;
        data_list[1] = inner;
        data_list[2] = cols;
        item_valid <= 1'b0;
        while (product_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        for (int w = 0; w < 3; w++)
        begin
            cfg_index <= reg_list[w];
            cfg_data  <= data_list[w];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            case (reg_list[w])
                CFG_ROWS_A:    dim_rows  = data_list[w];
                CFG_INNER_DIM: dim_inner = data_list[w];
                default:       dim_cols  = data_list[w];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // load every operand not yet written, then start the multiply
    task automatic compute_product();
        int unsigned m;
        int unsigned n;
        int unsigned k;
        m = effective_dim(dim_rows);
        n = effective_dim(dim_inner);
        k = effective_dim(dim_cols);
        for (int i = 0; i < m; i++)
        begin
            for (int p = 0; p < n; p++)
            begin
                if (!a_loaded[ADDR_W'(i * MAX_DIM + p)])
                begin
                    send_item(OP_LOAD_A, IDX_W'(i), IDX_W'(p), random_value());
                end
            end
        end
        for (int p = 0; p < n; p++)
        begin
            for (int j = 0; j < k; j++)
            begin
                if (!b_loaded[ADDR_W'(p * MAX_DIM + j)])
                begin
                    send_item(OP_LOAD_B, IDX_W'(p), IDX_W'(j), random_value());
                end
            end
        end
        send_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    task automatic test_basic_products();
        set_dims(4'd1, 4'd1, 4'd1);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0001_0000);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h0002_8000);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        send_item(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_item(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        // negative products round towards minus infinity
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0001_8000);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'hFFFF_8000);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h0000_0001);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        // stored although outside the current dimensions
        send_item(OP_LOAD_A, 3'd5, 3'd0, 32'h0003_0000);
        send_item(OP_LOAD_B, 3'd0, 3'd7, 32'h7FFF_FFFF);
    endtask

    task automatic test_dimension_extremes();
        set_dims(4'd8, 4'd0, 4'd15);
        compute_product();
    endtask

    // hold the result side off so that the command queue fills
    task automatic test_queue_fill();
        set_dims(4'd4, 4'd2, 4'd4);
        no_idle        = 1'b1;
        long_stall_req = 1'b1;
        compute_product();
        repeat (8)
        begin
            send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, IDX_W'($urandom),
                      IDX_W'($urandom), random_value());
        end
        compute_product();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        logic [1:0]  op;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                set_dims(pick_dim(), pick_dim(), pick_dim());
            end
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    op = OP_UNUSED;
                end
                else
                begin
                    op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
                end
                send_item(op, IDX_W'($urandom), IDX_W'($urandom), random_value());
            end
            compute_product();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else
            begin
                rx_gap = no_idle ? 0 : $urandom_range(0, 15);
                if (rx_gap != 0)
                begin
                    result_ready <= 1'b0;
                    repeat (rx_gap) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!(result_valid || long_stall_req))
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (product_queue.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected result transaction: value %h row %0d col %0d",
                             result.product_value, result.out_row, result.out_col);
                end
                mismatches++;
            end
            else
            begin
                next_elem = product_queue.pop_front();
                if (result.product_value !== next_elem.product_value ||
                    result.out_row !== next_elem.out_row ||
                    result.out_col !== next_elem.out_col ||
                    result.saturated !== next_elem.saturated ||
                    result.last !== next_elem.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display({"mismatch: expected %h r%0d c%0d sat %b last %b,",
                                  " got %h r%0d c%0d sat %b last %b"},
                                 next_elem.product_value, next_elem.out_row,
                                 next_elem.out_col, next_elem.saturated, next_elem.last,
                                 result.product_value, result.out_row, result.out_col,
                                 result.saturated, result.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_products();
        test_dimension_extremes();
        test_queue_fill();
        test_random_traffic();
        item_valid <= 1'b0;
        while (product_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && product_queue.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
